@@ hw/rtl/ropl_pkg.sv @@
package ropl_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int PID_W = 16;
    localparam int VA_W = 39;
    localparam int PA_W = 56;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_REMOVE = 3'd1,
        FN_TOUCH  = 3'd2,
        FN_EVICT  = 3'd3,
        FN_FREE   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHIFT,
        PH_RESP
    } phase_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [VA_W-1:0]  va;
        logic [PA_W-1:0]  pa;
    } entry_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic             shift;
        logic [2:0]       func;
        logic [PID_W-1:0] pid;
        logic [VA_W-1:0]  va;
        logic [PA_W-1:0]  pa;
    } cell_cmd_t;

endpackage

@@ hw/rtl/ropl_cell.sv @@
// One position of the recency chain. Position 0 is the most recent entry.
// In a shift cycle the chain is rebuilt: a cell either keeps its entry,
// takes its upstream neighbor's (entry moves one step older), or takes the
// entry handed down from the next older cell (gap closes).
module ropl_cell import ropl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  logic      prev_valid,
    input  entry_t    prev_entry,
    input  logic      next_valid,
    input  entry_t    next_entry,
    input  logic      head_pass_in,
    input  logic      del_before,
    input  logic      del_self,
    input  logic      del_next,
    output logic      valid,
    output entry_t    entry,
    output logic      hit_pa,
    output logic      hit_pv,
    output logic      hit_pid
);

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign hit_pa = valid_reg && entry_reg.pa == cmd.pa;
    assign hit_pv = valid_reg && entry_reg.pid == cmd.pid && entry_reg.va == cmd.va;
    assign hit_pid = valid_reg && entry_reg.pid == cmd.pid;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.shift) begin
            case (cmd.func)
                FN_ADD, FN_TOUCH: begin
                    if (head_pass_in) begin
                        valid_next = prev_valid;
                        entry_next = prev_entry;
                    end
                end
                FN_REMOVE, FN_EVICT, FN_FREE: begin
                    // compact: take the nearest surviving older entry
                    if (del_before || del_self) begin
                        valid_next = next_valid && !del_next;
                        entry_next = next_entry;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

@@ hw/rtl/ropl_chain.sv @@
module ropl_chain import ropl_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_cmd_t              cmd,
    input  logic [TABLE_DEPTH-1:0] del_mask,
    input  logic [TABLE_DEPTH-1:0] touch_pass,
    input  logic [TABLE_DEPTH-1:0] pick,
    input  entry_t                 head_in,
    output logic [TABLE_DEPTH-1:0] valid_vec,
    output logic [TABLE_DEPTH-1:0] hit_pa_vec,
    output logic [TABLE_DEPTH-1:0] hit_pv_vec,
    output logic [TABLE_DEPTH-1:0] hit_pid_vec,
    output entry_t                 head_entry,
    output entry_t                 pick_entry
);

    entry_t entries [TABLE_DEPTH];

    assign head_entry = entries[0];

    // pick is one-hot: entry of the selected cell
    always_comb begin
        pick_entry = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (pick[i]) begin
                pick_entry = entries[i];
            end
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic   pv, nv, db, dn;
        entry_t pe, ne;
        // add/touch feed the head with the command payload or touched entry
        if (i == 0) begin : g_head
            assign pv = 1'b1;
            assign db = 1'b0;
            assign pe = head_in;
        end else begin : g_body
            assign pv = valid_vec[i-1];
            assign db = |del_mask[i-1:0];
            assign pe = entries[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign nv = 1'b0;
            assign ne = entries[i];
            assign dn = 1'b0;
        end else begin : g_mid
            assign nv = valid_vec[i+1];
            assign ne = entries[i+1];
            assign dn = del_mask[i+1];
        end
        ropl_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .prev_valid   (pv),
            .prev_entry   (pe),
            .next_valid   (nv),
            .next_entry   (ne),
            .head_pass_in (touch_pass[i]),
            .del_before   (db),
            .del_self     (del_mask[i]),
            .del_next     (dn),
            .valid        (valid_vec[i]),
            .entry        (entries[i]),
            .hit_pa       (hit_pa_vec[i]),
            .hit_pv       (hit_pv_vec[i]),
            .hit_pid      (hit_pid_vec[i])
        );
    end

endmodule

@@ hw/rtl/recency_ordered_page_list_top.sv @@
// channel | direction | ports
// s_      | in        | s_valid s_ready s_func s_proc_id s_virt_page s_phys_page
// m_      | out       | m_valid m_ready m_status m_victim_pid m_victim_va
//         |           | m_victim_pa m_removed_count
// An item goes through accept (PH_IDLE), chain update (PH_SHIFT) and result
// (PH_RESP), which is held until m_ready. Entries stay packed in recency
// order. Free updates the chain once per deleted entry plus one final check
// that finds no match. Reset clears all valid bits at once; no item is taken
// while a result waits on m_ready.
module recency_ordered_page_list_top import ropl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_func,
    input  logic [PID_W-1:0] s_proc_id,
    input  logic [VA_W-1:0]  s_virt_page,
    input  logic [PA_W-1:0]  s_phys_page,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [PID_W-1:0] m_victim_pid,
    output logic [VA_W-1:0]  m_victim_va,
    output logic [PA_W-1:0]  m_victim_pa,
    output logic [7:0]       m_removed_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    phase_t ph_reg, ph_next;
    cell_cmd_t cmd;
    logic [2:0]       func_reg;
    logic [PID_W-1:0] pid_reg;
    logic [VA_W-1:0]  va_reg;
    logic [PA_W-1:0]  pa_reg;
    logic [1:0]       status_reg, status_next;
    entry_t           victim_reg, victim_next;
    logic [7:0]       cnt_reg, cnt_next;

    logic [TABLE_DEPTH-1:0] valid_vec, hit_pa_vec, hit_pv_vec, hit_pid_vec;
    logic [TABLE_DEPTH-1:0] del_mask, touch_pass, sel, first_hit;
    entry_t head_entry, pick_entry, head_in;
    logic [IDX_W-1:0] first_idx;
    logic any_hit, shift, entry_sel;

    assign cmd = '{shift: shift, func: func_reg, pid: pid_reg, va: va_reg, pa: pa_reg};

    // touch moves the matched entry to the head, add inserts the payload
    assign head_in = (func_reg == FN_TOUCH) ? pick_entry
                                            : '{pid: pid_reg, va: va_reg, pa: pa_reg};

    ropl_chain u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .del_mask    (del_mask),
        .touch_pass  (touch_pass),
        .pick        (first_hit),
        .head_in     (head_in),
        .valid_vec   (valid_vec),
        .hit_pa_vec  (hit_pa_vec),
        .hit_pv_vec  (hit_pv_vec),
        .hit_pid_vec (hit_pid_vec),
        .head_entry  (head_entry),
        .pick_entry  (pick_entry)
    );

    always_comb begin
        case (func_reg)
            FN_REMOVE: sel = hit_pa_vec;
            FN_TOUCH:  sel = hit_pv_vec;
            FN_EVICT:  sel = valid_vec;
            FN_FREE:   sel = hit_pid_vec;
            default:   sel = '0;
        endcase
    end

    // first set bit of sel: most recent match
    assign first_hit = sel & (~sel + TABLE_DEPTH'(1));
    assign any_hit = |sel;

    always_comb begin
        first_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (first_hit[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    // touch: cells 0..idx take from their upstream; cell 0 gets matched entry
    always_comb begin
        touch_pass = '0;
        del_mask = '0;
        case (func_reg)
            FN_ADD: touch_pass = '1;
            FN_TOUCH: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    touch_pass[i] = (IDX_W'(i) <= first_idx);
                end
            end
            FN_REMOVE, FN_EVICT, FN_FREE: del_mask = first_hit;
            default: ;
        endcase
    end

    assign entry_sel = (func_reg == FN_ADD) ? !valid_vec[TABLE_DEPTH-1] : any_hit;

    always_comb begin
        ph_next = ph_reg;
        case (ph_reg)
            PH_IDLE:  if (s_valid) ph_next = PH_SHIFT;
            PH_SHIFT: begin
                if (!(func_reg == FN_FREE && any_hit)) ph_next = PH_RESP;
            end
            PH_RESP:  if (m_ready) ph_next = PH_IDLE;
            default:  ph_next = PH_IDLE;
        endcase
    end

    always_comb begin
        shift = 1'b0;
        status_next = status_reg;
        victim_next = victim_reg;
        cnt_next = cnt_reg;
        if (ph_reg == PH_SHIFT) begin
            shift = entry_sel;
            case (func_reg)
                FN_ADD: status_next = entry_sel ? ST_DONE : ST_FULL;
                FN_FREE: begin
                    if (any_hit && cnt_reg != 8'hFF) cnt_next = cnt_reg + 8'd1;
                    status_next = (any_hit || cnt_reg != 8'd0) ? ST_DONE : ST_NONE;
                end
                FN_EVICT: begin
                    status_next = any_hit ? ST_DONE : ST_NONE;
                    if (any_hit) victim_next = head_entry;
                end
                FN_REMOVE, FN_TOUCH: status_next = any_hit ? ST_DONE : ST_NONE;
                default: status_next = ST_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_IDLE;
        end else begin
            ph_reg <= ph_next;
        end
        if (ph_reg == PH_IDLE && s_valid) begin
            func_reg <= s_func;
            pid_reg <= s_proc_id;
            va_reg <= s_virt_page;
            pa_reg <= s_phys_page;
            victim_reg <= '0;
            cnt_reg <= '0;
            status_reg <= ST_NONE;
        end else begin
            status_reg <= status_next;
            victim_reg <= victim_next;
            cnt_reg <= cnt_next;
        end
    end

    assign s_ready = (ph_reg == PH_IDLE);
    assign m_valid = (ph_reg == PH_RESP);
    assign m_status = status_reg;
    assign m_victim_pid = victim_reg.pid;
    assign m_victim_va = victim_reg.va;
    assign m_victim_pa = victim_reg.pa;
    assign m_removed_count = cnt_reg;

endmodule
